// File: hdl/layer_blend_unit_core_macros.svh
`ifndef LAYER_BLEND_UNIT_CORE_MACROS_SVH
`define LAYER_BLEND_UNIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define LBU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |-> cons) else $error(msg);

// Next-cycle implication, disabled while reset is held
`define LBU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// File: hdl/lbu_pkg.sv
package lbu_pkg;

    localparam int C_CHANNEL_BITS  = 16;
    localparam int C_FRACTION_BITS = 12;
    localparam int C_MODE_W        = 3;
    localparam int C_OPACITY_W     = 13;
    localparam int C_CFG_W         = 13;
    localparam int C_CFG_IDX_W     = 1;

    localparam logic [C_OPACITY_W-1:0] C_OPACITY_RESET = 13'd4096;

    typedef enum logic [C_MODE_W-1:0] {
        MODE_ADD     = 3'd0,
        MODE_AVERAGE = 3'd1,
        MODE_SCREEN  = 3'd2,
        MODE_LIGHTEN = 3'd3,
        MODE_DARKEN  = 3'd4
    } t_blend_mode;

    localparam logic [C_CFG_IDX_W-1:0] REG_BLEND_MODE    = 1'b0;
    localparam logic [C_CFG_IDX_W-1:0] REG_LAYER_OPACITY = 1'b1;

    typedef struct packed {
        logic [C_CHANNEL_BITS-1:0] base_red;
        logic [C_CHANNEL_BITS-1:0] base_green;
        logic [C_CHANNEL_BITS-1:0] base_blue;
        logic [C_CHANNEL_BITS-1:0] layer_red;
        logic [C_CHANNEL_BITS-1:0] layer_green;
        logic [C_CHANNEL_BITS-1:0] layer_blue;
    } t_pix_in;

    typedef struct packed {
        logic [C_CHANNEL_BITS-1:0] out_red;
        logic [C_CHANNEL_BITS-1:0] out_green;
        logic [C_CHANNEL_BITS-1:0] out_blue;
    } t_pix_out;

endpackage

// File: hdl/layer_blend_unit_core.sv
// Blends a layer pixel onto a base pixel, one pixel per clock. A pixel is taken on
// every clock edge with start high (busy is always low). Its result is on o_result
// with o_valid high for exactly one cycle, in order. Between the transfer and the
// result lies the five-stage pipeline (input register, opacity multiply, rule
// evaluation, screen multiply, output register). The receiver cannot stall the
// block: every result must be taken in the cycle it is shown. Write blend_mode
// and layer_opacity only while no pixel is in the pipeline.
`include "layer_blend_unit_core_macros.svh"

module layer_blend_unit_core
    import lbu_pkg::*;
#(
    parameter int FRACTION_BITS = C_FRACTION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_pix_in                i_pixel,
    output logic                   o_valid,
    output t_pix_out               o_result,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [C_CFG_W-1:0]     i_cfg_data
);

    localparam int LATENCY = 5;
    localparam int OW      = FRACTION_BITS + 1;
    localparam int CMPW    = (OW > C_OPACITY_W) ? OW : C_OPACITY_W;

    localparam logic [CMPW-1:0] ONE_C = CMPW'(1) << FRACTION_BITS;

    logic [C_MODE_W-1:0]       r_mode;
    logic [C_OPACITY_W-1:0]    r_opacity;
    logic [CMPW-1:0]           opacity_e;
    logic [OW-1:0]             op;
    logic [LATENCY-1:0]        r_vld;
    logic [LATENCY-1:0]        n_vld;
    logic                      accept;
    t_pix_in                   r_pix;
    logic [C_CHANNEL_BITS-1:0] res_red;
    logic [C_CHANNEL_BITS-1:0] res_green;
    logic [C_CHANNEL_BITS-1:0] res_blue;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ADD;
            r_opacity <= C_OPACITY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLEND_MODE:    r_mode    <= i_cfg_data[C_MODE_W-1:0];
                REG_LAYER_OPACITY: r_opacity <= i_cfg_data[C_OPACITY_W-1:0];
                default:           r_mode    <= r_mode;
            endcase
        end
    end

    // clamp opacity to full
    assign opacity_e = CMPW'(r_opacity);
    assign op        = (opacity_e > ONE_C) ? ONE_C[OW-1:0] : opacity_e[OW-1:0];

    assign n_vld = {r_vld[LATENCY-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= i_pixel;
        end
    end

    lbu_channel #(.FRACTION_BITS(FRACTION_BITS)) u_red (
        .i_clk    (i_clk),
        .i_base   (r_pix.base_red),
        .i_layer  (r_pix.layer_red),
        .i_mode   (r_mode),
        .i_op     (op),
        .o_result (res_red)
    );

    lbu_channel #(.FRACTION_BITS(FRACTION_BITS)) u_green (
        .i_clk    (i_clk),
        .i_base   (r_pix.base_green),
        .i_layer  (r_pix.layer_green),
        .i_mode   (r_mode),
        .i_op     (op),
        .o_result (res_green)
    );

    lbu_channel #(.FRACTION_BITS(FRACTION_BITS)) u_blue (
        .i_clk    (i_clk),
        .i_base   (r_pix.base_blue),
        .i_layer  (r_pix.layer_blue),
        .i_mode   (r_mode),
        .i_op     (op),
        .o_result (res_blue)
    );

    assign o_result = {res_red, res_green, res_blue};
    assign o_valid  = r_vld[LATENCY-1];

    `LBU_ASSERT_IMPL(a_result_follows, i_clk, i_rst_n, accept, ##LATENCY o_valid, "transfer lost in pipeline")
    `LBU_ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, o_valid, $past(accept, LATENCY), "result without transfer")
    `LBU_ASSERT_IMPL(a_add_not_below, i_clk, i_rst_n, o_valid && (r_mode == MODE_ADD), o_result.out_red >= $past(i_pixel.base_red, LATENCY), "additive result below base")
    `LBU_ASSERT_IMPL(a_lighten_not_below, i_clk, i_rst_n, o_valid && (r_mode == MODE_LIGHTEN), o_result.out_green >= $past(i_pixel.base_green, LATENCY), "lighten result below base")

endmodule

// File: hdl/lbu_channel.sv
module lbu_channel
    import lbu_pkg::*;
#(
    parameter int FRACTION_BITS = C_FRACTION_BITS
) (
    input  logic                      i_clk,
    input  logic [C_CHANNEL_BITS-1:0] i_base,
    input  logic [C_CHANNEL_BITS-1:0] i_layer,
    input  logic [C_MODE_W-1:0]       i_mode,
    input  logic [FRACTION_BITS:0]    i_op,
    output logic [C_CHANNEL_BITS-1:0] o_result
);

    localparam int CB  = C_CHANNEL_BITS;
    localparam int OW  = FRACTION_BITS + 1;
    localparam int EW  = ((CB > OW) ? CB : OW) + 1;
    localparam int PLW = CB + OW;
    localparam int PBW = CB + OW + 1;
    localparam int SW  = PBW + 1;
    localparam int QW  = 2 * OW;

    localparam logic [OW-1:0] ONE      = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [OW:0]   TWO_ONE  = {1'b1, {OW{1'b0}}};
    localparam logic [CB-1:0] CHAN_MAX = '1;

    logic [OW:0]     inv_weight;
    logic [PLW-1:0]  n1_prod_l;
    logic [PBW-1:0]  n1_prod_b;
    logic [CB-1:0]   r1_base;
    logic [PLW-1:0]  r1_prod_l;
    logic [PBW-1:0]  r1_prod_b;

    logic [CB-1:0]   scaled;
    logic [SW-1:0]   avg_sum;
    logic [CB:0]     add_sum;
    logic [CB-1:0]   add_sat;
    logic [EW-1:0]   base_e;
    logic [EW-1:0]   scaled_e;
    logic [EW-1:0]   one_e;
    logic [EW-1:0]   thresh_e;
    logic [CB-1:0]   darken;
    logic [CB-1:0]   n2_res;
    logic [OW-1:0]   n2_fb;
    logic [OW-1:0]   n2_fl;
    logic [CB-1:0]   r2_res;
    logic [OW-1:0]   r2_fb;
    logic [OW-1:0]   r2_fl;

    logic [QW-1:0]   n3_prod;
    logic [QW-1:0]   r3_prod;
    logic [CB-1:0]   r3_res;

    logic [OW-1:0]   scr;
    logic [EW-1:0]   scr_e;
    logic [CB-1:0]   scr_sat;
    logic [CB-1:0]   n4_res;
    logic [CB-1:0]   r4_res;

    // stage 1: opacity products
    assign inv_weight = TWO_ONE - {1'b0, i_op};
    assign n1_prod_l  = PLW'(i_layer) * PLW'(i_op);
    assign n1_prod_b  = PBW'(i_base) * PBW'(inv_weight);

    always_ff @(posedge i_clk) begin
        r1_base   <= i_base;
        r1_prod_l <= n1_prod_l;
        r1_prod_b <= n1_prod_b;
    end

    // stage 2: per-rule results and screen factors
    assign scaled   = r1_prod_l[FRACTION_BITS +: CB];
    assign avg_sum  = SW'(r1_prod_b) + SW'(r1_prod_l);
    assign add_sum  = {1'b0, r1_base} + {1'b0, scaled};
    assign add_sat  = add_sum[CB] ? CHAN_MAX : add_sum[CB-1:0];
    assign base_e   = EW'(r1_base);
    assign scaled_e = EW'(scaled);
    assign one_e    = EW'(ONE);
    assign thresh_e = scaled_e + EW'(ONE - i_op);
    assign darken   = (base_e < thresh_e) ? r1_base : thresh_e[CB-1:0];
    assign n2_fb    = (base_e < one_e) ? (ONE - OW'(r1_base)) : '0;
    assign n2_fl    = (scaled_e < one_e) ? (ONE - OW'(scaled)) : '0;

    always_comb begin
        case (i_mode)
            MODE_ADD:     n2_res = add_sat;
            MODE_AVERAGE: n2_res = avg_sum[FRACTION_BITS+1 +: CB];
            MODE_LIGHTEN: n2_res = (r1_base > scaled) ? r1_base : scaled;
            MODE_DARKEN:  n2_res = darken;
            default:      n2_res = r1_base;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r2_res <= n2_res;
        r2_fb  <= n2_fb;
        r2_fl  <= n2_fl;
    end

    // stage 3: screen product
    assign n3_prod = QW'(r2_fb) * QW'(r2_fl);

    always_ff @(posedge i_clk) begin
        r3_prod <= n3_prod;
        r3_res  <= r2_res;
    end

    // stage 4: screen finish, saturate, select
    assign scr     = ONE - r3_prod[FRACTION_BITS +: OW];
    assign scr_e   = EW'(scr);
    assign scr_sat = (scr_e > EW'(CHAN_MAX)) ? CHAN_MAX : scr_e[CB-1:0];
    assign n4_res  = (i_mode == MODE_SCREEN) ? scr_sat : r3_res;

    always_ff @(posedge i_clk) begin
        r4_res <= n4_res;
    end

    assign o_result = r4_res;

endmodule
